>>> design/bmh_pkg.sv
// Package for the binary max-heap engine: status codes, operation codes and sequencer states.
// Used by binary_max_heap_engine_core; depends on nothing.
package bmh_pkg;
	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_BADPOS = 2'd2;
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DELETE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEL_RD,
		S_DEL_WAIT,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RDL,
		S_DN_RDR,
		S_DN_CMP,
		S_TOP_RD,
		S_TOP_WAIT,
		S_OUT
	} state_t;
endpackage

>>> design/binary_max_heap_engine_core.sv
// Binary max-heap engine top level: heap memory, live count and sift sequencer.
// Depends on bmh_pkg.
//
// channel   ports                                         handshake
// command   start, operation, value, position            start & !busy
// result    done, status, entry_count, top_value,         done, one cycle
//           removed_value
//
// A rejected command goes straight to the top-of-heap read and the result strobe. An insert
// writes the new entry at the end and sifts it up. A delete reads the removed entry and the
// last entry, moves the last into the freed slot and, unless that slot was the last, sinks
// it and then lets it rise. busy falls in the cycle after the strobe. One memory with a write
// port and a registered read port serves every step. Reset clears the count and control;
// memory contents need no clearing. The receiver cannot stall, so done is high for one cycle.
module binary_max_heap_engine_core #(
	parameter int HEAP_DEPTH = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic                       operation,
	input  logic signed [31:0]         value,
	input  logic [$clog2(HEAP_DEPTH+1)-1:0] position,
	output logic                       done,
	output logic [1:0]                 status,
	output logic [$clog2(HEAP_DEPTH+1)-1:0] entry_count,
	output logic signed [31:0]         top_value,
	output logic signed [31:0]         removed_value
);
	import bmh_pkg::*;

	localparam int CW = $clog2(HEAP_DEPTH + 1);
	localparam int AW = $clog2(HEAP_DEPTH + 1);

	logic signed [31:0] mem [0:HEAP_DEPTH];
	logic signed [31:0] rdata_q;
	logic [AW-1:0] raddr;
	logic          we;
	logic [AW-1:0] waddr;
	logic signed [31:0] wdata;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] slot_q, slot_d;
	logic signed [31:0] key_q, key_d;
	logic signed [31:0] lval_q, lval_d;
	logic signed [31:0] rem_q, rem_d;
	logic signed [31:0] top_q, top_d;
	logic [1:0] stat_q, stat_d;
	logic [AW-1:0] del_pos_q, del_pos_d;

	logic [AW:0] lc, rc;
	logic [AW-1:0] parent;
	logic lc_ok, rc_ok;
	logic signed [31:0] best_val;
	logic [AW:0] best_idx;
	logic take_r, take_l;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		slot_q    <= slot_d;
		key_q     <= key_d;
		lval_q    <= lval_d;
		rem_q     <= rem_d;
		top_q     <= top_d;
		stat_q    <= stat_d;
		del_pos_q <= del_pos_d;
	end

	assign lc = {slot_q, 1'b0};
	assign rc = {slot_q, 1'b1};
	assign parent = slot_q >> 1;
	assign lc_ok = lc <= {1'b0, count_q};
	assign rc_ok = rc <= {1'b0, count_q};
	assign take_r = rc_ok && (rdata_q > key_q);
	always_comb begin
		best_val = take_r ? rdata_q : key_q;
		best_idx = take_r ? rc : {1'b0, slot_q};
		take_l = lc_ok && (lval_q > best_val);
		if (take_l) begin
			best_val = lval_q;
			best_idx = lc;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		slot_d = slot_q;
		key_d = key_q;
		lval_d = lval_q;
		rem_d = rem_q;
		top_d = top_q;
		stat_d = stat_q;
		del_pos_d = del_pos_q;
		raddr = slot_q;
		we = 1'b0;
		waddr = slot_q;
		wdata = key_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					rem_d = '0;
					stat_d = ST_DONE;
					if (operation == OP_INSERT) begin
						if (count_q >= CW'(HEAP_DEPTH)) begin
							stat_d = ST_FULL;
							state_d = S_TOP_RD;
						end else begin
							count_d = count_q + 1'b1;
							slot_d = AW'(count_q + 1'b1);
							key_d = value;
							we = 1'b1;
							waddr = AW'(count_q + 1'b1);
							wdata = value;
							state_d = S_UP_RD;
						end
					end else begin
						if (position == '0 || position > count_q) begin
							stat_d = ST_BADPOS;
							state_d = S_TOP_RD;
						end else begin
							del_pos_d = position;
							raddr = position;
							state_d = S_DEL_RD;
						end
					end
				end
			end
			S_DEL_RD: begin
				rem_d = rdata_q;
				raddr = count_q;
				state_d = S_DEL_WAIT;
			end
			S_DEL_WAIT: begin
				key_d = rdata_q;
				we = 1'b1;
				waddr = del_pos_q;
				wdata = rdata_q;
				count_d = count_q - 1'b1;
				slot_d = del_pos_q;
				if (del_pos_q <= count_q - 1'b1) begin
					state_d = S_DN_RDL;
				end else begin
					state_d = S_TOP_RD;
				end
			end
			S_DN_RDL: begin
				raddr = lc_ok ? lc[AW-1:0] : slot_q;
				state_d = S_DN_RDR;
			end
			S_DN_RDR: begin
				lval_d = rdata_q;
				raddr = rc_ok ? rc[AW-1:0] : slot_q;
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				state_d = S_DN_CMP;
				if (best_idx == {1'b0, slot_q}) begin
					state_d = S_UP_RD;
				end else begin
					we = 1'b1;
					waddr = slot_q;
					wdata = best_val;
					slot_d = best_idx[AW-1:0];
					state_d = S_DN_RDL;
				end
			end
			S_UP_RD: begin
				if (slot_q == AW'(1)) begin
					we = 1'b1;
					state_d = S_TOP_RD;
				end else begin
					raddr = parent;
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (key_q > rdata_q) begin
					we = 1'b1;
					waddr = slot_q;
					wdata = rdata_q;
					slot_d = parent;
					state_d = S_UP_RD;
				end else begin
					we = 1'b1;
					state_d = S_TOP_RD;
				end
			end
			S_TOP_RD: begin
				raddr = AW'(1);
				state_d = S_TOP_WAIT;
			end
			S_TOP_WAIT: begin
				top_d = (count_q != '0) ? rdata_q : '0;
				state_d = S_OUT;
			end
			S_OUT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_OUT;
	assign status = stat_q;
	assign entry_count = count_q;
	assign top_value = top_q;
	assign removed_value = rem_q;

	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe held longer than one cycle");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HEAP_DEPTH)) else $error("entry count above depth");
	a_bad_nochg: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_DONE |-> $stable(count_q))
		else $error("rejected operation changed the count");
endmodule
